/* hdl/longest_common_substring_length_top_macros.svh */
// Assertion macros for the longest common substring length block
`ifndef LONGEST_COMMON_SUBSTRING_LENGTH_TOP_MACROS_SVH
`define LONGEST_COMMON_SUBSTRING_LENGTH_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define LCSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define LCSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lcsl_pkg.sv */
// Shared constants for the longest common substring length block
package lcsl_pkg;

    localparam int MAX_LEN = 1024;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CHAR_W  = 8;
    localparam int OP_W    = 2;
    localparam int LEN_W   = 11;
    localparam int LEN_MAX = 2047;

    localparam logic [OP_W-1:0] OP_FIRST   = 2'd0;
    localparam logic [OP_W-1:0] OP_SECOND  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

endpackage

/* hdl/lcsl_ram.sv */
// Generic simple dual-port RAM with registered read
module lcsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/longest_common_substring_length_top.sv */
// Longest common substring length: string stores, DP sequencer and result register.
// Operations 0 and 1 append one character per cycle and are taken back to back.
// Operation 2 walks the DP table one cell per cycle through a single compare and
// increment unit and the run_row memory port, with a row setup state before each row
// and a flush state after the last, then registers the result once the output is
// not stalled; it goes straight to the result when either string is empty. The
// block takes no transaction meanwhile. No clearing pass is needed after reset.
module longest_common_substring_length_top
    import lcsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [CHAR_W-1:0] i_character,
    output logic              o_stall,
    output logic              o_valid,
    output logic [LEN_W-1:0]  o_length,
    output logic              o_overflow,
    input  logic              i_stall
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROW   = 5'b00010,
        S_SWEEP = 5'b00100,
        S_FLUSH = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count1, n_count1;
    logic [CNT_W-1:0]   r_count2, n_count2;
    logic               r_ovf, n_ovf;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [CNT_W-1:0]   r_col, n_col;
    logic               r_pv, n_pv;
    logic [ADDR_W-1:0]  r_pcol, n_pcol;
    logic               r_pfirst, n_pfirst;
    logic [CNT_W-1:0]   r_diag, n_diag;
    logic [CNT_W-1:0]   r_best, n_best;
    logic               r_ovalid, n_ovalid;
    logic [LEN_W-1:0]   r_olen, n_olen;
    logic               r_oovf, n_oovf;

    logic               accept;
    logic               first_wr, second_wr;
    logic [CHAR_W-1:0]  first_rd, second_rd;
    logic [CNT_W-1:0]   run_rd, run_old, diag, run_next;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    assign first_wr  = accept && (i_operation == OP_FIRST)
                       && (r_count1 < CNT_W'(MAX_LEN));
    assign second_wr = accept && (i_operation == OP_SECOND)
                       && (r_count2 < CNT_W'(MAX_LEN));

    lcsl_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_text (
        .i_clk     (i_clk),
        .i_wr_en   (first_wr),
        .i_wr_addr (r_count1[ADDR_W-1:0]),
        .i_wr_data (i_character),
        .i_rd_en   (r_state == S_ROW),
        .i_rd_addr (r_row[ADDR_W-1:0]),
        .o_rd_data (first_rd)
    );

    lcsl_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_text (
        .i_clk     (i_clk),
        .i_wr_en   (second_wr),
        .i_wr_addr (r_count2[ADDR_W-1:0]),
        .i_wr_data (i_character),
        .i_rd_en   (r_state == S_SWEEP),
        .i_rd_addr (r_col[ADDR_W-1:0]),
        .o_rd_data (second_rd)
    );

    lcsl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_run_row (
        .i_clk     (i_clk),
        .i_wr_en   (r_pv),
        .i_wr_addr (r_pcol),
        .i_wr_data (run_next),
        .i_rd_en   (r_state == S_SWEEP),
        .i_rd_addr (r_col[ADDR_W-1:0]),
        .o_rd_data (run_rd)
    );

    // first row sees an all-zero previous row
    assign run_old  = r_pfirst ? '0 : run_rd;
    assign diag     = (r_pcol == '0) ? '0 : r_diag;
    assign run_next = (first_rd == second_rd) ? diag + CNT_W'(1) : '0;

    always_comb begin
        n_state  = r_state;
        n_count1 = r_count1;
        n_count2 = r_count2;
        n_ovf    = r_ovf;
        n_row    = r_row;
        n_col    = r_col;
        n_pv     = 1'b0;
        n_pcol   = r_pcol;
        n_pfirst = r_pfirst;
        n_diag   = r_diag;
        n_best   = r_best;
        n_ovalid = r_ovalid;
        n_olen   = r_olen;
        n_oovf   = r_oovf;

        if (r_pv) begin
            n_diag = run_old;
            if (run_next > r_best) begin
                n_best = run_next;
            end
        end

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_operation == OP_FIRST) begin
                        if (first_wr) begin
                            n_count1 = r_count1 + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (i_operation == OP_SECOND) begin
                        if (second_wr) begin
                            n_count2 = r_count2 + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (i_operation == OP_COMPUTE) begin
                        n_best = '0;
                        n_row  = '0;
                        if (r_count1 == '0 || r_count2 == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_ROW;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ROW: begin
                n_col   = '0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                n_pv     = 1'b1;
                n_pcol   = r_col[ADDR_W-1:0];
                n_pfirst = (r_row == '0);
                n_col    = r_col + CNT_W'(1);
                if (r_col + CNT_W'(1) == r_count2) begin
                    if (r_row + CNT_W'(1) == r_count1) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_row   = r_row + CNT_W'(1);
                        n_state = S_ROW;
                    end
                end
            end
            S_FLUSH: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    if (32'(r_best) > 32'(LEN_MAX)) begin
                        n_olen = LEN_W'(LEN_MAX);
                    end else begin
                        n_olen = LEN_W'(r_best);
                    end
                    n_oovf   = r_ovf;
                    n_count1 = '0;
                    n_count2 = '0;
                    n_ovf    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count1 <= '0;
            r_count2 <= '0;
            r_ovf    <= 1'b0;
            r_pv     <= 1'b0;
            r_best   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count1 <= n_count1;
            r_count2 <= n_count2;
            r_ovf    <= n_ovf;
            r_pv     <= n_pv;
            r_best   <= n_best;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_col    <= n_col;
        r_pcol   <= n_pcol;
        r_pfirst <= n_pfirst;
        r_diag   <= n_diag;
        r_olen   <= n_olen;
        r_oovf   <= n_oovf;
    end

    assign o_valid    = r_ovalid;
    assign o_length   = r_olen;
    assign o_overflow = r_oovf;

endmodule

/* hdl/lcsl_checker.sv */
// Port-level assertions for the longest common substring length block
`include "longest_common_substring_length_top_macros.svh"

module lcsl_checker
    import lcsl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic [OP_W-1:0]   i_operation,
    input logic              o_stall,
    input logic              o_valid,
    input logic [LEN_W-1:0]  o_length,
    input logic              o_overflow,
    input logic              i_stall
);

    `LCSL_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_length) && $stable(o_overflow), "result changed while stalled")
    `LCSL_ASSERT_NOW(a_len_bound, o_valid, 32'(o_length) <= MAX_LEN, "length beyond string capacity")
    `LCSL_ASSERT_NEXT(a_compute_busy, i_valid && !o_stall && i_operation == OP_COMPUTE, o_stall, "compute transaction did not occupy the block")
    `LCSL_ASSERT_NEXT(a_append_fast, i_valid && !o_stall && (i_operation == OP_FIRST || i_operation == OP_SECOND), !o_stall, "append transaction stalled the next one")

endmodule

bind longest_common_substring_length_top lcsl_checker u_lcsl_checker (.*);

/* test/longest_common_substring_length_checker.sv */
// Checker for the longest common substring length block: predicts and compares results
`timescale 1ns / 1ps

module longest_common_substring_length_checker
    import lcsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [CHAR_W-1:0] i_character,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [LEN_W-1:0]  i_length,
    input  logic              i_overflow,
    output int                o_errors,
    output int                o_pending,
    output int                o_results,
    output int                o_overflows
);

    typedef struct packed {
        logic [LEN_W-1:0] run_length;
        logic             dropped;
    } substring_result_t;

    logic [CHAR_W-1:0] first_text [MAX_LEN];
    logic [CHAR_W-1:0] second_text [MAX_LEN];
    int                first_len = 0;
    int                second_len = 0;
    logic              too_long = 1'b0;
    substring_result_t expected_results [$];

    // single row of run counters, walked right to left so the diagonal is still the old row
    function automatic logic [LEN_W-1:0] longest_run();
        int unsigned run [MAX_LEN];
        int unsigned best;
        int unsigned diag;
        int          i;
        int          j;
        best = 0;
        for (j = 0; j < MAX_LEN; j++) run[ADDR_W'(j)] = 0;
        for (i = 0; i < first_len; i++) begin
            for (j = second_len - 1; j >= 0; j--) begin
                if (first_text[ADDR_W'(i)] == second_text[ADDR_W'(j)]) begin
                    diag = (j > 0) ? run[ADDR_W'(j-1)] : 0;
                    run[ADDR_W'(j)] = diag + 1;
                    if (run[ADDR_W'(j)] > best) best = run[ADDR_W'(j)];
                end else begin
                    run[ADDR_W'(j)] = 0;
                end
            end
        end
        if (best > LEN_MAX) best = LEN_MAX;
        return best[LEN_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        substring_result_t want;
        if (!i_rst_n) begin
            first_len = 0;
            second_len = 0;
            too_long = 1'b0;
        end else begin
            // result side first: a compute taken this cycle cannot have its result out yet
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result length %0d overflow %0d",
                             $time, i_length, i_overflow);
                end else begin
                    want = expected_results.pop_front();
                    o_results++;
                    if (i_overflow) o_overflows++;
                    if (i_length !== want.run_length) begin
                        o_errors++;
                        $display("%0t: length expected %0d actual %0d",
                                 $time, want.run_length, i_length);
                    end
                    if (i_overflow !== want.dropped) begin
                        o_errors++;
                        $display("%0t: overflow expected %0d actual %0d",
                                 $time, want.dropped, i_overflow);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_operation)
                    OP_FIRST: begin
                        if (first_len < MAX_LEN) begin
                            first_text[ADDR_W'(first_len)] = i_character;
                            first_len++;
                        end else begin
                            too_long = 1'b1;
                        end
                    end
                    OP_SECOND: begin
                        if (second_len < MAX_LEN) begin
                            second_text[ADDR_W'(second_len)] = i_character;
                            second_len++;
                        end else begin
                            too_long = 1'b1;
                        end
                    end
                    OP_COMPUTE: begin
                        want.run_length = longest_run();
                        want.dropped = too_long;
                        expected_results.push_back(want);
                        first_len = 0;
                        second_len = 0;
                        too_long = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
        o_pending = expected_results.size();
    end

    final begin
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
    end

endmodule

/* test/longest_common_substring_length_top_test.sv */
// Testbench top for the longest common substring length block: stimulus and verdict
`timescale 1ns / 1ps

module longest_common_substring_length_top_test;
    import lcsl_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic [OP_W-1:0]   i_operation;
    logic [CHAR_W-1:0] i_character;
    logic              o_stall;
    logic              o_valid;
    logic [LEN_W-1:0]  o_length;
    logic              o_overflow;
    logic              i_stall;

    int errors;
    int pending;
    int results;
    int overflows;
    int sent = 0;
    bit quiet = 1'b0;
    bit held = 1'b0;

    longest_common_substring_length_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_character (i_character),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_length    (o_length),
        .o_overflow  (o_overflow),
        .i_stall     (i_stall)
    );

    longest_common_substring_length_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_operation (i_operation),
        .i_character (i_character),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_length    (o_length),
        .i_overflow  (o_overflow),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_overflows (overflows)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char(input int base, input int span);
        int value;
        value = base + $urandom_range(0, span);
        return value[CHAR_W-1:0];
    endfunction

    // called just after a rising edge; returns at the edge that takes the transaction
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_character <= ch;
        do @(posedge i_clk); while (o_stall);
        if (op != OP_UNUSED) sent++;
    endtask

    task automatic load_and_compute(input int first_total, input int second_total,
                                    input bit with_noise);
        int na;
        int nb;
        int base;
        int span;
        na = 0;
        nb = 0;
        base = $urandom_range(0, 255);
        span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 2);
        while (na < first_total || nb < second_total) begin
            if (with_noise && $urandom_range(0, 9) == 0) begin
                send_item(OP_UNUSED, CHAR_W'($urandom));
            end
            if (nb >= second_total || (na < first_total && $urandom_range(0, 1))) begin
                send_item(OP_FIRST, pick_char(base, span));
                na++;
            end else begin
                send_item(OP_SECOND, pick_char(base, span));
                nb++;
            end
        end
        send_item(OP_COMPUTE, CHAR_W'($urandom));
    endtask

    // receiver: random stalls, quiet stretches, and one long hold-off to back the block up
    initial begin
        i_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            int r;
            if (!held && results >= 15) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 20) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(20, 100)) @(posedge i_clk);
            end else if (r < 90) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int random_floor;
        int spin;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_FIRST;
        i_character = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty strings, unused operation, byte extremes, full and no match
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_COMPUTE, 8'hFF);
        send_item(OP_FIRST, 8'h00);
        send_item(OP_FIRST, 8'hFF);
        send_item(OP_SECOND, 8'hFF);
        send_item(OP_SECOND, 8'h00);
        send_item(OP_SECOND, 8'hFF);
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_SECOND, 8'h41);
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_FIRST, 8'h41);
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_FIRST, 8'hA5);
        send_item(OP_SECOND, 8'hA5);
        send_item(OP_FIRST, 8'h5A);
        send_item(OP_UNUSED, 8'h5A);
        send_item(OP_SECOND, 8'h5A);
        send_item(OP_FIRST, 8'hA5);
        send_item(OP_SECOND, 8'hA5);
        send_item(OP_COMPUTE, 8'h00);
        send_item(OP_FIRST, 8'h01);
        send_item(OP_SECOND, 8'h02);
        send_item(OP_COMPUTE, 8'h00);

        // string exactly full, then each string overrun
        load_and_compute(MAX_LEN, 1, 1'b0);
        load_and_compute(MAX_LEN + 3, 3, 1'b0);
        load_and_compute(2, MAX_LEN + 2, 1'b0);

        random_floor = sent + RANDOM_ITEMS;
        while (sent < random_floor) begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85) begin
                load_and_compute(
                    ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8),
                    ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8),
                    1'b1);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom));
                end
            end
        end
        send_item(OP_COMPUTE, CHAR_W'($urandom));
        i_valid <= 1'b0;

        spin = 0;
        while (pending != 0 && spin < 100000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (20) @(posedge i_clk);

        $display("run covered %0d accepted transactions and %0d checked results,", sent, results);
        $display("%0d of them with dropped characters, %0d still outstanding", overflows, pending);
        if (errors == 0 && pending == 0) begin
            $display("longest_common_substring_length_top_test: clean");
        end else begin
            $display("longest_common_substring_length_top_test: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", pending);
        $display("longest_common_substring_length_top_test: errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/lcsl_pkg.sv
hdl/lcsl_ram.sv
hdl/longest_common_substring_length_top.sv
hdl/lcsl_checker.sv
test/longest_common_substring_length_checker.sv
test/longest_common_substring_length_top_test.sv
